@@ rtl/sma_pkg.sv @@
`timescale 1ns / 1ps

package sma_pkg;

    // Word and stack geometry
    localparam int WORD_W      = 32;
    localparam int STACK_DEPTH = 64;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(WORD_W);

    // Request opcodes
    typedef logic [3:0] req_code_t;
    localparam req_code_t REQ_PUSH = 4'd0;
    localparam req_code_t REQ_POP  = 4'd1;
    localparam req_code_t REQ_SWAP = 4'd2;
    localparam req_code_t REQ_ADD  = 4'd3;
    localparam req_code_t REQ_NOP  = 4'd4;
    localparam req_code_t REQ_SUB  = 4'd5;
    localparam req_code_t REQ_DIV  = 4'd6;
    localparam req_code_t REQ_MUL  = 4'd7;
    localparam req_code_t REQ_MOD  = 4'd8;

    // Result status codes
    typedef logic [2:0] status_t;
    localparam status_t STAT_OK      = 3'd0;
    localparam status_t STAT_EMPTY   = 3'd1;
    localparam status_t STAT_SHORT   = 3'd2;
    localparam status_t STAT_DIVZERO = 3'd3;
    localparam status_t STAT_FULL    = 3'd4;

    // Operations of the serial arithmetic unit
    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_MOD
    } alu_op_t;

endpackage

@@ rtl/sma_ram.sv @@
`timescale 1ns / 1ps

module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/sma_serial_alu.sv @@
`timescale 1ns / 1ps

module sma_serial_alu import sma_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  alu_op_t           op,
    input  logic [WORD_W-1:0] left,
    input  logic [WORD_W-1:0] right,
    output logic              busy,
    output logic              done,
    output logic [WORD_W-1:0] result
);

    typedef enum logic [1:0] {
        AL_IDLE,
        AL_RUN,
        AL_FIX
    } al_state_t;

    al_state_t         state_reg;
    alu_op_t           op_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] acc_reg;
    logic              carry_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_q_reg;
    logic              neg_r_reg;
    logic              done_reg;
    logic [WORD_W-1:0] result_reg;

    logic              sum_bit;
    logic              carry_next;
    logic [WORD_W:0]   trial;

    function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
        magnitude = v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
    endfunction

    // One full-adder bit and one restoring-division trial per cycle
    always_comb begin
        {carry_next, sum_bit} = 2'(a_reg[0]) + 2'(b_reg[0]) + 2'(carry_reg);
        trial = {acc_reg, a_reg[WORD_W-1]} - {1'b0, b_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AL_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= (state_reg == AL_FIX);
            unique case (state_reg)
                AL_IDLE: begin
                    // Load operands; division works on magnitudes
                    if (start) begin
                        op_reg    <= op;
                        acc_reg   <= '0;
                        carry_reg <= (op == ALU_SUB);
                        cnt_reg   <= '0;
                        neg_q_reg <= left[WORD_W-1] ^ right[WORD_W-1];
                        neg_r_reg <= left[WORD_W-1];
                        if (op == ALU_DIV || op == ALU_MOD) begin
                            a_reg <= magnitude(left);
                            b_reg <= magnitude(right);
                        end else begin
                            a_reg <= left;
                            b_reg <= (op == ALU_SUB) ? ~right : right;
                        end
                        state_reg <= AL_RUN;
                    end
                end
                AL_RUN: begin
                    unique case (op_reg)
                        ALU_ADD, ALU_SUB: begin
                            // Shift one sum bit in from the top
                            acc_reg   <= {sum_bit, acc_reg[WORD_W-1:1]};
                            carry_reg <= carry_next;
                            a_reg     <= {1'b0, a_reg[WORD_W-1:1]};
                            b_reg     <= {1'b0, b_reg[WORD_W-1:1]};
                        end
                        ALU_MUL: begin
                            // Add the shifted multiplicand for each set bit
                            if (b_reg[0]) begin
                                acc_reg <= acc_reg + a_reg;
                            end
                            a_reg <= {a_reg[WORD_W-2:0], 1'b0};
                            b_reg <= {1'b0, b_reg[WORD_W-1:1]};
                        end
                        default: begin
                            // Restoring divide: one quotient bit per cycle
                            if (!trial[WORD_W]) begin
                                acc_reg <= trial[WORD_W-1:0];
                                a_reg   <= {a_reg[WORD_W-2:0], 1'b1};
                            end else begin
                                acc_reg <= {acc_reg[WORD_W-2:0], a_reg[WORD_W-1]};
                                a_reg   <= {a_reg[WORD_W-2:0], 1'b0};
                            end
                        end
                    endcase
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(WORD_W - 1)) begin
                        state_reg <= AL_FIX;
                    end
                end
                AL_FIX: begin
                    // Apply the signs of quotient and remainder
                    unique case (op_reg)
                        ALU_DIV: result_reg <= neg_q_reg ? (~a_reg + WORD_W'(1)) : a_reg;
                        ALU_MOD: result_reg <= neg_r_reg ? (~acc_reg + WORD_W'(1)) : acc_reg;
                        default: result_reg <= acc_reg;
                    endcase
                    state_reg <= AL_IDLE;
                end
                default: state_reg <= AL_IDLE;
            endcase
        end
    end

    assign busy   = (state_reg != AL_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Never start while a computation is underway
    assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy)
        else $error("serial alu started while busy");

    // A result follows the sign-fix cycle and nothing else
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(state_reg) == AL_FIX)
        else $error("serial alu done without fix cycle");

    // The step counter is only active during the run phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == AL_IDLE && !start) |=> cnt_reg == $past(cnt_reg))
        else $error("serial alu counter moved while idle");

endmodule

@@ rtl/stack_machine_alu_unit.sv @@
`timescale 1ns / 1ps

// Stack machine ALU: a LIFO of up to STACK_DEPTH signed 32-bit words that runs one opcode per
// input transfer and returns one result transfer with status, top of stack and depth. Push, nop,
// a pop that empties the stack and every error go from idle straight to the done state; swap
// and a pop that leaves entries behind pass through a read state first, since the entry below
// the top comes out of a RAM with registered read. Add, sub, mul, div and mod go through a
// bit-serial unit that spends 32 steps, one bit per cycle, plus load and sign-fix states. One
// item is in work at a time; a new input transfer is taken as soon as the previous result is
// registered, even if that result has not been taken.
// The top entry lives in a register; the entries below it live in the RAM, which needs no
// clearing after reset.
module stack_machine_alu_unit import sma_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // req_type[3:0], push_value[35:4], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[2:0], top_value[34:3], stack_depth[41:35], zero fill
);

    localparam int OUT_DEPTH_W = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_DONE
    } state_t;

    state_t             state_reg;
    req_code_t          op_reg;
    status_t            status_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [WORD_W-1:0]  top_reg;
    logic               m_tvalid_reg;
    logic [47:0]        m_tdata_reg;

    req_code_t          in_req;
    logic [WORD_W-1:0]  in_value;
    logic               in_fire;
    logic               out_free;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    logic               alu_start;
    alu_op_t            alu_op;
    logic               alu_busy;
    logic               alu_done;
    logic [WORD_W-1:0]  alu_result;

    assign in_req   = s_tdata[3:0];
    assign in_value = s_tdata[35:4];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Steer the RAM: spill the old top on push, write back on swap
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(depth_reg - DEPTH_W'(2));
        ram_raddr = ADDR_W'(depth_reg - DEPTH_W'(2));
        if (in_fire && in_req == REQ_PUSH && depth_reg != '0 &&
            depth_reg != DEPTH_W'(STACK_DEPTH)) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(depth_reg - DEPTH_W'(1));
        end else if (state_reg == ST_READ && op_reg == REQ_SWAP) begin
            ram_we = 1'b1;
        end
    end

    // Map the opcode onto the serial unit
    always_comb begin
        alu_start = (state_reg == ST_READ) && (op_reg != REQ_POP) && (op_reg != REQ_SWAP);
        unique case (op_reg)
            REQ_SUB: alu_op = ALU_SUB;
            REQ_MUL: alu_op = ALU_MUL;
            REQ_DIV: alu_op = ALU_DIV;
            REQ_MOD: alu_op = ALU_MOD;
            default: alu_op = ALU_ADD;
        endcase
    end

    sma_ram #(
        .WIDTH(WORD_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(top_reg),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    sma_serial_alu u_alu (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (alu_start),
        .op     (alu_op),
        .left   (ram_rdata),
        .right  (top_reg),
        .busy   (alu_busy),
        .done   (alu_done),
        .result (alu_result)
    );

    // Sequence one request and hold the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            depth_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        op_reg     <= in_req;
                        status_reg <= STAT_OK;
                        state_reg  <= ST_DONE;
                        unique case (in_req)
                            REQ_PUSH: begin
                                if (depth_reg == DEPTH_W'(STACK_DEPTH)) begin
                                    status_reg <= STAT_FULL;
                                end else begin
                                    top_reg   <= in_value;
                                    depth_reg <= depth_reg + DEPTH_W'(1);
                                end
                            end
                            REQ_POP: begin
                                if (depth_reg == '0) begin
                                    status_reg <= STAT_EMPTY;
                                end else begin
                                    depth_reg <= depth_reg - DEPTH_W'(1);
                                    if (depth_reg >= DEPTH_W'(2)) begin
                                        state_reg <= ST_READ;
                                    end
                                end
                            end
                            REQ_SWAP, REQ_ADD, REQ_SUB, REQ_MUL: begin
                                if (depth_reg < DEPTH_W'(2)) begin
                                    status_reg <= STAT_SHORT;
                                end else begin
                                    state_reg <= ST_READ;
                                end
                            end
                            REQ_DIV, REQ_MOD: begin
                                if (depth_reg < DEPTH_W'(2)) begin
                                    status_reg <= STAT_SHORT;
                                end else if (top_reg == '0) begin
                                    status_reg <= STAT_DIVZERO;
                                end else begin
                                    state_reg <= ST_READ;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_READ: begin
                    // Second entry is on the RAM read port now
                    if (op_reg == REQ_POP || op_reg == REQ_SWAP) begin
                        top_reg   <= ram_rdata;
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    if (alu_done) begin
                        top_reg   <= alu_result;
                        depth_reg <= depth_reg - DEPTH_W'(1);
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'b0, OUT_DEPTH_W'(depth_reg),
                                         (depth_reg == '0) ? WORD_W'(0) : top_reg,
                                         status_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Depth stays within the stack
    assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    // A new result appears only out of the done state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside done state");

    // RAM writes stay below the current top
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (DEPTH_W'(ram_waddr) < depth_reg))
        else $error("stack write above top");

    // The serial unit is only in use while computing
    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_busy |-> state_reg == ST_CALC)
        else $error("serial alu busy outside compute state");

endmodule
